[rtl/core/fts_pkg.sv]
package fts_pkg;

  // Default table size
  localparam int unsigned DEPTH_DEFAULT = 256;

  // Field widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 8;

  // Command queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  // Input function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  // Operation after classification
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // One classified request
  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] key;
  } cmd_t;

  // One result from the back end
  typedef struct packed {
    logic               done;
    status_t            status;
    logic [INDEX_W-1:0] index;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIB   = 6'b000010,
    S_PROBE = 6'b000100,
    S_CMP   = 6'b001000,
    S_FINAL = 6'b010000,
    S_FCMP  = 6'b100000
  } bstate_t;

endpackage

[rtl/core/fts_ram.sv]
module fts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fts_front.sv]
module fts_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  func,
  input  logic [fts_pkg::VALUE_W-1:0] value,
  output logic                        busy,
  input  logic                        q_full,
  output logic                        push,
  output fts_pkg::cmd_t               push_cmd
);

  logic          fv;
  fts_pkg::cmd_t fcmd;
  fts_pkg::op_t  op_dec;

  // Map the function field onto an operation
  always_comb begin
    case (func)
      fts_pkg::FUNC_CLEAR:  op_dec = fts_pkg::OP_CLEAR;
      fts_pkg::FUNC_APPEND: op_dec = fts_pkg::OP_APPEND;
      fts_pkg::FUNC_SEARCH: op_dec = fts_pkg::OP_SEARCH;
      default:              op_dec = fts_pkg::OP_NOP;
    endcase
  end

  // Hold off only when the input stage is loaded and cannot drain
  assign busy     = fv && q_full;
  assign push     = fv && !q_full;
  assign push_cmd = fcmd;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (start && !busy) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      fcmd.op  <= op_dec;
      fcmd.key <= value;
    end
  end

endmodule

[rtl/core/fts_queue.sv]
module fts_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fts_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output fts_pkg::cmd_t head
);

  fts_pkg::cmd_t                 entry [fts_pkg::Q_DEPTH];
  logic [fts_pkg::Q_AW-1:0]      wr_ptr;
  logic [fts_pkg::Q_AW-1:0]      rd_ptr;
  logic [fts_pkg::Q_CW-1:0]      fill;

  assign full      = (fill == fts_pkg::Q_CW'(fts_pkg::Q_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entry[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/core/fts_back.sv]
module fts_back #(
  parameter int unsigned DEPTH = fts_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  fts_pkg::cmd_t                  q_head,
  output logic                           pop,
  output fts_pkg::res_t                  res,
  output logic [$clog2(DEPTH+1)-1:0]     cnt
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = CW + 1;

  fts_pkg::bstate_t            state;
  logic [CW-1:0]               count;
  logic [CW-1:0]               n;
  logic [fts_pkg::VALUE_W-1:0] key;
  logic [FW-1:0]               f2, f1, fm;
  logic [CW-1:0]               base;
  logic [AW-1:0]               probe_addr;

  logic                        we;
  logic [AW-1:0]               raddr;
  logic [fts_pkg::VALUE_W-1:0] rdata;
  logic [CW+1:0]               probe_sum;
  logic [CW-1:0]               nm1;
  logic [AW-1:0]               i_sel;
  logic [FW-1:0]               gt_f1;
  logic [AW+7:0]               ext_probe, ext_base;
  logic                        has_room;

  assign cnt      = count;
  assign has_room = (count < CW'(DEPTH));
  assign pop      = (state == fts_pkg::S_IDLE) && q_valid;
  assign we       = pop && (q_head.op == fts_pkg::OP_APPEND) && has_room;

  // Probe address: base + f2 - 1, clamped to the last entry
  always_comb begin
    probe_sum = (CW+2)'(base) + (CW+2)'(f2) - (CW+2)'(1);
    nm1       = n - CW'(1);
    i_sel     = (probe_sum > (CW+2)'(nm1)) ? AW'(nm1) : AW'(probe_sum);
    raddr     = (state == fts_pkg::S_PROBE) ? i_sel : AW'(base);
    gt_f1     = f1 - f2;
    ext_probe = (AW+8)'(probe_addr);
    ext_base  = (AW+8)'(base);
  end

  fts_ram #(
    .WIDTH (fts_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(count)),
    .wdata (q_head.key),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fts_pkg::S_IDLE;
      count    <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        fts_pkg::S_IDLE: begin
          if (q_valid) begin
            res.index <= '0;
            case (q_head.op)
              fts_pkg::OP_CLEAR: begin
                count      <= '0;
                res.done   <= 1'b1;
                res.status <= fts_pkg::ST_OK;
              end
              fts_pkg::OP_APPEND: begin
                res.done <= 1'b1;
                if (has_room) begin
                  count      <= count + CW'(1);
                  res.status <= fts_pkg::ST_OK;
                end else begin
                  res.status <= fts_pkg::ST_FULL;
                end
              end
              fts_pkg::OP_SEARCH: begin
                if (count == '0) begin
                  res.done   <= 1'b1;
                  res.status <= fts_pkg::ST_EMPTY;
                end else begin
                  n     <= count;
                  key   <= q_head.key;
                  f2    <= '0;
                  f1    <= FW'(1);
                  fm    <= FW'(1);
                  base  <= '0;
                  state <= fts_pkg::S_FIB;
                end
              end
              default: begin
                res.done   <= 1'b1;
                res.status <= fts_pkg::ST_OK;
              end
            endcase
          end
        end
        // Grow the Fibonacci triple until fm covers n
        fts_pkg::S_FIB: begin
          if (fm < FW'(n)) begin
            f2 <= f1;
            f1 <= fm;
            fm <= f1 + fm;
          end else if (fm > FW'(1)) begin
            state <= fts_pkg::S_PROBE;
          end else begin
            state <= fts_pkg::S_FINAL;
          end
        end
        fts_pkg::S_PROBE: begin
          probe_addr <= i_sel;
          state      <= fts_pkg::S_CMP;
        end
        // Compare probe against key and narrow the range
        fts_pkg::S_CMP: begin
          if (rdata < key) begin
            fm    <= f1;
            f1    <= f2;
            f2    <= gt_f1;
            base  <= CW'(probe_addr) + CW'(1);
            state <= (f1 > FW'(1)) ? fts_pkg::S_PROBE : fts_pkg::S_FINAL;
          end else if (rdata > key) begin
            fm    <= f2;
            f1    <= gt_f1;
            f2    <= f2 - gt_f1;
            state <= (f2 > FW'(1)) ? fts_pkg::S_PROBE : fts_pkg::S_FINAL;
          end else begin
            res.done   <= 1'b1;
            res.status <= fts_pkg::ST_OK;
            res.index  <= ext_probe[7:0];
            state      <= fts_pkg::S_IDLE;
          end
        end
        // Last check of entry base, if it lies inside the table
        fts_pkg::S_FINAL: begin
          if (base < n) begin
            state <= fts_pkg::S_FCMP;
          end else begin
            res.done   <= 1'b1;
            res.status <= fts_pkg::ST_MISS;
            res.index  <= '0;
            state      <= fts_pkg::S_IDLE;
          end
        end
        fts_pkg::S_FCMP: begin
          res.done <= 1'b1;
          if (rdata == key) begin
            res.status <= fts_pkg::ST_OK;
            res.index  <= ext_base[7:0];
          end else begin
            res.status <= fts_pkg::ST_MISS;
            res.index  <= '0;
          end
          state <= fts_pkg::S_IDLE;
        end
        default: begin
          state <= fts_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/fibonacci_table_search_core.sv]
// Channel   Handshake           Payload
// request   start / busy        func[1:0], value[31:0]
// result    done (one cycle)    status[1:0], index[7:0]
//
// A request passes the input stage and a two-entry queue, then the back end
// takes it one at a time. Clear, append and unused codes finish one cycle
// after the back end picks them up. In the back end a search first runs the
// Fibonacci build steps until the sequence reaches the entry count, then the
// probes (each a table read plus compare) until the key is found or missed.
// Reset (rst, synchronous) empties the table count and the queue.
// busy rises only when the queue and input stage are both full; results
// come out on done for exactly one cycle and are never held.
module fibonacci_table_search_core #(
  parameter int unsigned DEPTH = fts_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [fts_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [fts_pkg::INDEX_W-1:0]   index
);

  logic                         q_full;
  logic                         q_valid;
  logic                         push;
  logic                         pop;
  fts_pkg::cmd_t                push_cmd;
  fts_pkg::cmd_t                q_head;
  fts_pkg::res_t                res;
  logic [$clog2(DEPTH+1)-1:0]   cnt;

  fts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .value    (value),
    .busy     (busy),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  fts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  fts_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .res     (res),
    .cnt     (cnt)
  );

  assign done   = res.done;
  assign status = res.status;
  assign index  = res.index;

  // Only a found key carries a nonzero index
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == fts_pkg::ST_MISS || status == fts_pkg::ST_EMPTY ||
             status == fts_pkg::ST_FULL) |-> index == '0)
    else $error("nonzero index on a non-found result");

  // Busy only when the queue cannot take the held request
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_full)
    else $error("busy while queue has room");

  // Table count never passes the depth
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("entry count above depth");

  // A full-table result leaves the count at the depth
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    done && status == fts_pkg::ST_FULL |-> cnt == ($clog2(DEPTH+1))'(DEPTH))
    else $error("full status with room in table");

endmodule
